@@ rtl/midi_voice_allocator_unit_defines.svh @@
// ---------------------------------------------------------------------------
// Assertion macros for the voice allocator
// Concurrent checks that drop out of synthesis builds.
// ---------------------------------------------------------------------------
`ifndef MIDI_VOICE_ALLOCATOR_UNIT_DEFINES_SVH
`define MIDI_VOICE_ALLOCATOR_UNIT_DEFINES_SVH
`ifndef SYNTH
// The property must hold at every clock edge outside reset.
`define MVA_ASSERT(label, clk, rst, prop) \
   label: assert property (@(posedge clk) disable iff (rst) prop) \
      else $error("voice allocator assertion failed");
// The condition must never be true outside reset.
`define MVA_NEVER(label, clk, rst, cond) \
   label: assert property (@(posedge clk) disable iff (rst) !(cond)) \
      else $error("voice allocator forbidden condition seen");
`else
`define MVA_ASSERT(label, clk, rst, prop)
`define MVA_NEVER(label, clk, rst, cond)
`endif
`endif

@@ rtl/mva_pkg.sv @@
// ---------------------------------------------------------------------------
// Voice allocator package
// Shared constants, types and a helper function of the voice allocator.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps

package mva_pkg;

   localparam int NOTE_COUNT  = 128;
   localparam int VOICE_COUNT = 4;
   // The voice field is two bits wide, so at most four voices are driven.
   localparam int VOICES_USED = (VOICE_COUNT > 4) ? 4 : VOICE_COUNT;
   localparam int NOTE_W      = $clog2(NOTE_COUNT);

   localparam logic [7:0] IDLE_PITCH   = 8'd255;
   localparam logic [6:0] TOP_NOTE     = 7'd127;
   localparam logic [6:0] VEL_LOW_EDGE = 7'd64;
   localparam logic [3:0] DUO_CHANNEL  = 4'd14;
   localparam logic [3:0] MONO_CHANNEL = 4'd0;

   localparam logic [1:0] REQ_NOTE_ON  = 2'd0;
   localparam logic [1:0] REQ_NOTE_OFF = 2'd1;
   localparam logic [1:0] REQ_ALL_OFF  = 2'd2;

   typedef enum logic [2:0] {
      CLS_NONE,
      CLS_MONO_ON,
      CLS_MONO_OFF,
      CLS_POLY_ON,
      CLS_POLY_OFF,
      CLS_DIRECT_ON,
      CLS_DIRECT_OFF,
      CLS_ALL_OFF
   } cls_type;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_SETUP,
      ST_SCAN,
      ST_READ,
      ST_FINISH,
      ST_ALLOFF
   } state_type;

   // Commands from the controller to the datapath.
   typedef struct packed {
      logic load;
      logic setup;
      logic scan;
      logic read;
      logic finish;
      logic emit_off;
   } cmd_type;

   // Status from the datapath to the controller.
   typedef struct packed {
      cls_type cls;
      logic    needs_scan;
      logic    match;
      logic    scan_done;
      logic    off_last;
   } stat_type;

   // Direct channels 1 to 13 map onto voice (channel - 1) mod VOICES_USED.
   function automatic logic [1:0] direct_voice(input logic [3:0] ch);
      logic [3:0] rem;
      rem = ch - 4'd1;
      for (int i = 0; i < 8; i++) begin
         if (rem >= 4'(VOICES_USED)) begin
            rem = rem - 4'(VOICES_USED);
         end
      end
      return rem[1:0];
   endfunction

endpackage

@@ rtl/midi_voice_allocator_unit.sv @@
// ---------------------------------------------------------------------------
// MIDI voice allocator
// Turns note events into gate and pitch commands for up to four voices.
// ---------------------------------------------------------------------------
// A request word is taken when start is high and busy is low; busy stays high
// until the request is done. Note on and note off words on the direct and
// polyphonic channels without a key search pass from setup straight to the
// result. A mono note on with keys held, a mono release with more than one
// key held and a polyphonic release that frees a voice search the held-key
// table one key per clock, lowest key first, stopping at the first match,
// then read the held velocity from the table memory. All notes off issues one
// gate stop per voice on consecutive cycles. Each result word is shown for
// exactly one cycle under rsp_strobe and must be taken then, as the receiver
// cannot stall the block; rsp_last_result marks the final word of a request.
`timescale 1ns / 1ps

module midi_voice_allocator_unit (
   input  logic       clock,
   input  logic       reset,
   input  logic       start,
   output logic       busy,
   input  logic [1:0] req_type,
   input  logic [3:0] req_midi_channel,
   input  logic [6:0] req_note_number,
   input  logic [6:0] req_note_velocity,
   output logic       rsp_strobe,
   output logic [1:0] rsp_voice,
   output logic       rsp_gate_start,
   output logic       rsp_gate_stop,
   output logic       rsp_pitch_update,
   output logic [6:0] rsp_pitch,
   output logic [6:0] rsp_velocity_out,
   output logic       rsp_velocity_low_flag,
   output logic       rsp_last_result
);

   mva_pkg::cmd_type  cmd;
   mva_pkg::stat_type stat;

   mva_controller u_controller (
      .clock (clock),
      .reset (reset),
      .start (start),
      .busy  (busy),
      .stat  (stat),
      .cmd   (cmd)
   );

   mva_datapath u_datapath (
      .clock                 (clock),
      .reset                 (reset),
      .cmd                   (cmd),
      .stat                  (stat),
      .req_type              (req_type),
      .req_midi_channel      (req_midi_channel),
      .req_note_number       (req_note_number),
      .req_note_velocity     (req_note_velocity),
      .rsp_strobe            (rsp_strobe),
      .rsp_voice             (rsp_voice),
      .rsp_gate_start        (rsp_gate_start),
      .rsp_gate_stop         (rsp_gate_stop),
      .rsp_pitch_update      (rsp_pitch_update),
      .rsp_pitch             (rsp_pitch),
      .rsp_velocity_out      (rsp_velocity_out),
      .rsp_velocity_low_flag (rsp_velocity_low_flag),
      .rsp_last_result       (rsp_last_result)
   );

endmodule

@@ rtl/mva_datapath.sv @@
// ---------------------------------------------------------------------------
// Voice allocator datapath
// Held-key table, voice pitches, key scan and the result register.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps

module mva_datapath (
   input  logic              clock,
   input  logic              reset,
   input  mva_pkg::cmd_type  cmd,
   output mva_pkg::stat_type stat,
   input  logic [1:0]        req_type,
   input  logic [3:0]        req_midi_channel,
   input  logic [6:0]        req_note_number,
   input  logic [6:0]        req_note_velocity,
   output logic              rsp_strobe,
   output logic [1:0]        rsp_voice,
   output logic              rsp_gate_start,
   output logic              rsp_gate_stop,
   output logic              rsp_pitch_update,
   output logic [6:0]        rsp_pitch,
   output logic [6:0]        rsp_velocity_out,
   output logic              rsp_velocity_low_flag,
   output logic              rsp_last_result
);

   localparam int VU = mva_pkg::VOICES_USED;

   // Latched request word.
   logic [1:0] type_ff;
   logic [3:0] chan_ff;
   logic [6:0] note_ff;
   logic [6:0] vel_ff;

   // Held keys: a valid bit per key, the velocity in a memory.
   logic [mva_pkg::NOTE_COUNT-1:0] valid_ff;
   logic [6:0] vel_mem [mva_pkg::NOTE_COUNT];
   logic [6:0] rd_ff;

   logic [7:0] vp_ff [VU];
   logic [7:0] keys_ff;
   logic [6:0] scan_ff;
   logic       hit_ff;
   logic [6:0] hit_idx_ff;
   logic [1:0] voice_ff;
   logic [1:0] off_ff;

   logic [1:0] rsp_voice_ff;
   logic       rsp_strobe_ff, rsp_start_ff, rsp_stop_ff, rsp_upd_ff, rsp_last_ff;
   logic [6:0] rsp_pitch_ff, rsp_vel_ff;

   mva_pkg::cls_type cls;
   logic [2:0] n_voices;
   logic [1:0] max_v, match_v, dir_v;
   logic       match, playing, hit_now;
   logic       fin_start, fin_stop, fin_upd;
   logic [6:0] fin_pitch, fin_vel;

   // Classify the latched request.
   always_comb begin
      logic is_on;
      is_on = (type_ff == mva_pkg::REQ_NOTE_ON) && (vel_ff != 7'd0);
      if (is_on) begin
         if (chan_ff == mva_pkg::MONO_CHANNEL) cls = mva_pkg::CLS_MONO_ON;
         else if (chan_ff >= mva_pkg::DUO_CHANNEL) cls = mva_pkg::CLS_POLY_ON;
         else cls = mva_pkg::CLS_DIRECT_ON;
      end else if (type_ff inside {mva_pkg::REQ_NOTE_ON, mva_pkg::REQ_NOTE_OFF}) begin
         if (chan_ff == mva_pkg::MONO_CHANNEL) cls = mva_pkg::CLS_MONO_OFF;
         else if (chan_ff >= mva_pkg::DUO_CHANNEL) cls = mva_pkg::CLS_POLY_OFF;
         else cls = mva_pkg::CLS_DIRECT_OFF;
      end else if (type_ff == mva_pkg::REQ_ALL_OFF) begin
         cls = mva_pkg::CLS_ALL_OFF;
      end else begin
         cls = mva_pkg::CLS_NONE;
      end
   end

   // Voice selection: highest pitch to steal, matching pitch to free.
   always_comb begin
      logic [7:0] best;
      logic       found;
      n_voices = (chan_ff == mva_pkg::DUO_CHANNEL) ? 3'd2 : 3'(VU);
      dir_v    = mva_pkg::direct_voice(chan_ff);
      best     = 8'd0;
      max_v    = 2'd0;
      found    = 1'b0;
      match_v  = 2'd0;
      playing  = 1'b0;
      for (int i = 0; i < VU; i++) begin
         if (3'(i) < n_voices) begin
            if (vp_ff[i] >= best) begin
               best  = vp_ff[i];
               max_v = 2'(i);
            end
            if (!found && vp_ff[i] == {1'b0, note_ff}) begin
               found   = 1'b1;
               match_v = 2'(i);
            end
            if (vp_ff[i] == {1'b0, scan_ff}) playing = 1'b1;
         end
      end
      if (cls == mva_pkg::CLS_DIRECT_OFF) match = (vp_ff[dir_v] == {1'b0, note_ff});
      else match = found;
   end

   // Scan hit: a held key, and for a polyphonic release one no voice is sounding.
   assign hit_now = valid_ff[scan_ff] &&
                    !(cls == mva_pkg::CLS_POLY_OFF && playing);

   always_comb begin
      stat.cls       = cls;
      stat.match     = match;
      stat.scan_done = hit_now || (scan_ff == mva_pkg::TOP_NOTE);
      stat.off_last  = (off_ff == 2'(VU - 1));
      case (cls)
         mva_pkg::CLS_MONO_ON:  stat.needs_scan = (keys_ff != 8'd0);
         mva_pkg::CLS_MONO_OFF: stat.needs_scan = (keys_ff > 8'd1);
         mva_pkg::CLS_POLY_OFF: stat.needs_scan = match;
         default:               stat.needs_scan = 1'b0;
      endcase
   end

   // Result of a single-result request.
   always_comb begin
      fin_start = 1'b0;
      fin_stop  = 1'b0;
      fin_upd   = 1'b0;
      fin_pitch = note_ff;
      fin_vel   = vel_ff;
      case (cls)
         mva_pkg::CLS_MONO_ON: begin
            fin_upd   = (keys_ff == 8'd0) ||
                        (hit_ff ? (note_ff < hit_idx_ff) : (note_ff != mva_pkg::TOP_NOTE));
            fin_start = !((keys_ff != 8'd0) && fin_upd);
         end
         mva_pkg::CLS_POLY_ON, mva_pkg::CLS_DIRECT_ON: begin
            fin_upd   = 1'b1;
            fin_start = 1'b1;
         end
         mva_pkg::CLS_MONO_OFF, mva_pkg::CLS_POLY_OFF: begin
            fin_upd   = hit_ff;
            fin_stop  = !hit_ff;
            fin_pitch = hit_idx_ff;
            fin_vel   = rd_ff;
         end
         mva_pkg::CLS_DIRECT_OFF: fin_stop = 1'b1;
         default: fin_stop = 1'b0;
      endcase
   end

   // Control state.
   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff      <= '0;
         keys_ff       <= 8'd0;
         rsp_strobe_ff <= 1'b0;
         for (int i = 0; i < VU; i++) vp_ff[i] <= mva_pkg::IDLE_PITCH;
      end else begin
         rsp_strobe_ff <= cmd.finish || cmd.emit_off;
         if (cmd.setup) begin
            case (cls)
               mva_pkg::CLS_MONO_OFF: begin
                  valid_ff[note_ff] <= 1'b0;
                  if (keys_ff != 8'd0) keys_ff <= keys_ff - 8'd1;
               end
               mva_pkg::CLS_POLY_OFF: begin
                  valid_ff[note_ff] <= 1'b0;
                  if (match) vp_ff[match_v] <= mva_pkg::IDLE_PITCH;
               end
               mva_pkg::CLS_ALL_OFF: begin
                  valid_ff <= '0;
                  keys_ff  <= 8'd0;
                  for (int i = 0; i < VU; i++) vp_ff[i] <= mva_pkg::IDLE_PITCH;
               end
               default: keys_ff <= keys_ff;
            endcase
         end
         if (cmd.finish) begin
            case (cls)
               mva_pkg::CLS_MONO_ON: begin
                  valid_ff[note_ff] <= 1'b1;
                  if (keys_ff != 8'hFF) keys_ff <= keys_ff + 8'd1;
                  if (fin_upd) vp_ff[0] <= {1'b0, note_ff};
               end
               mva_pkg::CLS_POLY_ON: begin
                  valid_ff[note_ff] <= 1'b1;
                  vp_ff[voice_ff]   <= {1'b0, note_ff};
               end
               mva_pkg::CLS_DIRECT_ON: vp_ff[voice_ff] <= {1'b0, note_ff};
               mva_pkg::CLS_DIRECT_OFF: vp_ff[voice_ff] <= mva_pkg::IDLE_PITCH;
               mva_pkg::CLS_MONO_OFF, mva_pkg::CLS_POLY_OFF: begin
                  vp_ff[voice_ff] <= hit_ff ? {1'b0, hit_idx_ff} : mva_pkg::IDLE_PITCH;
               end
               default: keys_ff <= keys_ff;
            endcase
         end
      end
   end

   // Request latch, scan registers and the velocity memory.
   always_ff @(posedge clock) begin
      if (cmd.load) begin
         type_ff <= req_type;
         chan_ff <= req_midi_channel;
         note_ff <= req_note_number;
         vel_ff  <= req_note_velocity;
      end
      if (cmd.setup) begin
         scan_ff <= 7'd0;
         hit_ff  <= 1'b0;
         off_ff  <= 2'd0;
         case (cls)
            mva_pkg::CLS_POLY_ON:  voice_ff <= max_v;
            mva_pkg::CLS_POLY_OFF: voice_ff <= match_v;
            mva_pkg::CLS_DIRECT_ON, mva_pkg::CLS_DIRECT_OFF: voice_ff <= dir_v;
            default: voice_ff <= 2'd0;
         endcase
      end
      if (cmd.scan) begin
         scan_ff <= scan_ff + 7'd1;
         if (hit_now && !hit_ff) begin
            hit_ff     <= 1'b1;
            hit_idx_ff <= scan_ff;
         end
      end
      if (cmd.read) rd_ff <= vel_mem[hit_idx_ff];
      if (cmd.finish && (cls inside {mva_pkg::CLS_MONO_ON, mva_pkg::CLS_POLY_ON})) begin
         vel_mem[note_ff] <= vel_ff;
      end
      if (cmd.emit_off) off_ff <= off_ff + 2'd1;
   end

   // Result register.
   always_ff @(posedge clock) begin
      if (cmd.finish) begin
         rsp_voice_ff <= voice_ff;
         rsp_start_ff <= fin_start;
         rsp_stop_ff  <= fin_stop;
         rsp_upd_ff   <= fin_upd;
         rsp_pitch_ff <= fin_upd ? fin_pitch : 7'd0;
         rsp_vel_ff   <= fin_upd ? fin_vel : 7'd0;
         rsp_last_ff  <= 1'b1;
      end else if (cmd.emit_off) begin
         rsp_voice_ff <= off_ff;
         rsp_start_ff <= 1'b0;
         rsp_stop_ff  <= 1'b1;
         rsp_upd_ff   <= 1'b0;
         rsp_pitch_ff <= 7'd0;
         rsp_vel_ff   <= 7'd0;
         rsp_last_ff  <= stat.off_last;
      end
   end

   assign rsp_strobe            = rsp_strobe_ff;
   assign rsp_voice             = rsp_voice_ff;
   assign rsp_gate_start        = rsp_start_ff;
   assign rsp_gate_stop         = rsp_stop_ff;
   assign rsp_pitch_update      = rsp_upd_ff;
   assign rsp_pitch             = rsp_pitch_ff;
   assign rsp_velocity_out      = rsp_vel_ff;
   assign rsp_velocity_low_flag = rsp_upd_ff && (rsp_vel_ff < mva_pkg::VEL_LOW_EDGE);
   assign rsp_last_result       = rsp_last_ff;

endmodule

@@ rtl/mva_controller.sv @@
// ---------------------------------------------------------------------------
// Voice allocator controller
// Sequences setup, key scan, memory read and result issue per request.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps
`include "midi_voice_allocator_unit_defines.svh"

module mva_controller (
   input  logic              clock,
   input  logic              reset,
   input  logic              start,
   output logic              busy,
   input  mva_pkg::stat_type stat,
   output mva_pkg::cmd_type  cmd
);

   mva_pkg::state_type state_ff, state_in;

   // State register.
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= mva_pkg::ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   // Next state and commands.
   always_comb begin
      state_in = state_ff;
      cmd      = '0;
      case (state_ff)
         mva_pkg::ST_IDLE: begin
            if (start) begin
               cmd.load = 1'b1;
               state_in = mva_pkg::ST_SETUP;
            end
         end
         mva_pkg::ST_SETUP: begin
            cmd.setup = 1'b1;
            if (stat.cls == mva_pkg::CLS_NONE) begin
               state_in = mva_pkg::ST_IDLE;
            end else if ((stat.cls inside {mva_pkg::CLS_POLY_OFF, mva_pkg::CLS_DIRECT_OFF}) &&
                         !stat.match) begin
               state_in = mva_pkg::ST_IDLE;
            end else if (stat.cls == mva_pkg::CLS_ALL_OFF) begin
               state_in = mva_pkg::ST_ALLOFF;
            end else if (stat.needs_scan) begin
               state_in = mva_pkg::ST_SCAN;
            end else begin
               state_in = mva_pkg::ST_FINISH;
            end
         end
         mva_pkg::ST_SCAN: begin
            cmd.scan = 1'b1;
            if (stat.scan_done) state_in = mva_pkg::ST_READ;
         end
         mva_pkg::ST_READ: begin
            cmd.read = 1'b1;
            state_in = mva_pkg::ST_FINISH;
         end
         mva_pkg::ST_FINISH: begin
            cmd.finish = 1'b1;
            state_in   = mva_pkg::ST_IDLE;
         end
         mva_pkg::ST_ALLOFF: begin
            cmd.emit_off = 1'b1;
            if (stat.off_last) state_in = mva_pkg::ST_IDLE;
         end
         default: state_in = mva_pkg::ST_IDLE;
      endcase
   end

   assign busy = (state_ff != mva_pkg::ST_IDLE);

   // A new word is taken only while no request is in progress.
   `MVA_NEVER(a_load_idle, clock, reset, cmd.load && busy)
   // A finished scan always reads the held velocity next.
   `MVA_ASSERT(a_scan_read, clock, reset, cmd.scan && stat.scan_done |=> cmd.read)
   // A memory read is always followed by the result issue.
   `MVA_ASSERT(a_read_finish, clock, reset, cmd.read |=> cmd.finish)
   // After a single result the block is free again.
   `MVA_ASSERT(a_finish_idle, clock, reset, cmd.finish |=> !busy)

endmodule
